// ===== rtl/psag_pkg.sv =====
// Shared types and constants for the pixel shuffle address generator.
// No dependencies; imported by every module of the block.
package psag_pkg;

    // Default values of the top-level parameters
    localparam int INDEX_BITS_DEF = 24;
    localparam int MAX_DIM_DEF    = 4096;
    localparam int MAX_BLOCK_DEF  = 8;

    // Fixed field widths
    localparam int VALUE_W      = 32;
    localparam int IDX_OUT_W    = 24;
    localparam int BLOCK_CFG_W  = 4;
    localparam int DIM_CFG_W    = 13;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    // Job queue depth between front and back (power of two)
    localparam int FIFO_DEPTH = 2;

    // Register reset values
    localparam logic                   MODE_RST   = 1'b0;
    localparam logic [BLOCK_CFG_W-1:0] BLOCK_RST  = 4'd2;
    localparam logic [DIM_CFG_W-1:0]   WIDTH_RST  = 13'd1;
    localparam logic [DIM_CFG_W-1:0]   HEIGHT_RST = 13'd1;
    localparam logic [DIM_CFG_W-1:0]   CHAN_RST   = 13'd4;

    // Mode codes
    localparam logic MODE_D2S = 1'b0;
    localparam logic MODE_S2D = 1'b1;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_BLOCK    = 3'd1,
        REG_WIDTH    = 3'd2,
        REG_HEIGHT   = 3'd3,
        REG_CHANNELS = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_DIV4,
        ST_WO,
        ST_HO,
        ST_PY,
        ST_PX,
        ST_T,
        ST_PC,
        ST_ACC,
        ST_DST,
        ST_FIN
    } t_bk_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== rtl/psag_front.sv =====
// Front end: accepts elements, keeps the position counters and batch base.
// Depends on psag_pkg; feeds jobs into psag_fifo.
module psag_front
    import psag_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr,
    input  logic [$clog2(MAX_DIM+1)-1:0] i_w,
    input  logic [$clog2(MAX_DIM+1)-1:0] i_h,
    input  logic [$clog2(MAX_DIM+1)-1:0] i_c,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [VALUE_W-1:0]        i_value,
    input  logic                      i_first,
    input  t_fifo_stat                i_fifo,
    output logic                      o_push,
    output logic [$clog2(MAX_DIM)-1:0] o_x,
    output logic [$clog2(MAX_DIM)-1:0] o_y,
    output logic [$clog2(MAX_DIM)-1:0] o_ch,
    output logic [INDEX_BITS-1:0]     o_base,
    output logic [INDEX_BITS-1:0]     o_lin,
    output logic [VALUE_W-1:0]        o_value
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
    localparam logic [1:0] SETTLE_CYC = 2'd3;

    logic [CNT_W-1:0]      r_col, r_row, r_chan;
    logic [INDEX_BITS-1:0] r_base, r_lin;
    logic [CNT_W-1:0]      n_col, n_row, n_chan;
    logic [INDEX_BITS-1:0] n_base, n_lin;
    logic [1:0]            r_settle;
    logic [2*DIM_W-1:0]    r_wh;
    logic [3*DIM_W-1:0]    whc;
    logic [INDEX_BITS-1:0] r_plane;

    logic [CNT_W:0] col_inc, row_t, ch_t;
    logic           col_wrap, row_wrap, ch_wrap, carry_c, carry_b;

    // Plane size pipeline; the front holds off input while it settles after a register write
    assign whc = (3*DIM_W)'(r_wh) * (3*DIM_W)'(i_c);
    always_ff @(posedge i_clk) begin
        r_wh    <= (2*DIM_W)'(i_w) * (2*DIM_W)'(i_h);
        r_plane <= INDEX_BITS'(whc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYC;
        end else if (i_cfg_wr) begin
            r_settle <= SETTLE_CYC;
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    assign o_ready = (r_settle == 2'd0) && !i_fifo.full;
    assign o_push  = i_valid && o_ready;

    // Snapshot of the position; first clears everything before use
    assign o_x     = i_first ? '0 : r_col;
    assign o_y     = i_first ? '0 : r_row;
    assign o_ch    = i_first ? '0 : r_chan;
    assign o_base  = i_first ? '0 : r_base;
    assign o_lin   = i_first ? '0 : r_lin;
    assign o_value = i_value;

    always_comb begin
        col_inc  = (CNT_W+1)'(o_x) + (CNT_W+1)'(1);
        col_wrap = CMP_W'(col_inc) >= CMP_W'(i_w);
        row_t    = col_wrap ? (CNT_W+1)'(o_y) + (CNT_W+1)'(1) : (CNT_W+1)'(o_y);
        row_wrap = CMP_W'(row_t) >= CMP_W'(i_h);
        carry_c  = col_wrap && row_wrap;
        ch_t     = carry_c ? (CNT_W+1)'(o_ch) + (CNT_W+1)'(1) : (CNT_W+1)'(o_ch);
        ch_wrap  = CMP_W'(ch_t) >= CMP_W'(i_c);
        carry_b  = carry_c && ch_wrap;

        n_col  = col_wrap ? '0 : CNT_W'(col_inc);
        n_row  = row_wrap ? '0 : CNT_W'(row_t);
        n_chan = ch_wrap  ? '0 : CNT_W'(ch_t);
        n_base = carry_b ? o_base + r_plane : o_base;
        n_lin  = o_lin + INDEX_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_chan <= '0;
            r_base <= '0;
            r_lin  <= '0;
        end else if (o_push) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_chan <= n_chan;
            r_base <= n_base;
            r_lin  <= n_lin;
        end
    end

endmodule

// ===== rtl/psag_fifo.sv =====
// Short job queue between the front and back parts.
// Depends on psag_pkg for depth and the status struct.
module psag_fifo
    import psag_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output t_fifo_stat       o_stat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PTR_W+1)'(1);
            end
        end
    end

    assign o_rdata      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/psag_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on psag_pkg; shared by all divisions of the back part.
module psag_div
    import psag_pkg::*;
#(
    parameter int DIV_W = 13,
    parameter int DVS_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quo,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_dvd, r_quo;
    logic [DVS_W-1:0] r_dvs, r_rem;
    logic [DVS_W:0]   partial, diff;
    logic             ge;

    assign partial = {r_rem, r_dvd[DIV_W-1]};
    assign diff    = partial - (DVS_W+1)'(r_dvs);
    assign ge      = partial >= (DVS_W+1)'(r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? DVS_W'(diff) : DVS_W'(partial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/psag_back.sv =====
// Back part: turns a queued position into source and destination indices.
// Depends on psag_pkg and psag_div; holds the output register.
module psag_back
    import psag_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_mode,
    input  logic [$clog2(MAX_BLOCK+1)-1:0]  i_b,
    input  logic [$clog2(MAX_DIM+1)-1:0]    i_w,
    input  logic [$clog2(MAX_DIM+1)-1:0]    i_h,
    input  logic [$clog2(MAX_DIM+1)-1:0]    i_c,
    input  t_fifo_stat                      i_fifo,
    output logic                            o_pop,
    input  logic [$clog2(MAX_DIM)-1:0]      i_x,
    input  logic [$clog2(MAX_DIM)-1:0]      i_y,
    input  logic [$clog2(MAX_DIM)-1:0]      i_ch,
    input  logic [INDEX_BITS-1:0]           i_base,
    input  logic [INDEX_BITS-1:0]           i_lin,
    input  logic [VALUE_W-1:0]              i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [IDX_OUT_W-1:0]            o_src,
    output logic [IDX_OUT_W-1:0]            o_dst,
    output logic [VALUE_W-1:0]              o_data,
    output logic                            o_err
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int BLK_W = $clog2(MAX_BLOCK + 1);
    localparam int DVS_W = 2 * BLK_W;
    localparam int DIV_W = (DIM_W > DVS_W) ? DIM_W : DVS_W;
    localparam int OUT_W = DIM_W + BLK_W;
    localparam int PW    = INDEX_BITS + OUT_W;
    localparam int EXT_W = (INDEX_BITS > IDX_OUT_W) ? INDEX_BITS : IDX_OUT_W;

    t_bk_state r_state, n_state;
    logic      r_issued, n_issued;

    logic [CNT_W-1:0]      r_x, r_y, r_ch;
    logic [INDEX_BITS-1:0] r_base, r_lin;
    logic [VALUE_W-1:0]    r_val;
    logic [DVS_W-1:0]      r_r1, r_r2;
    logic [OUT_W-1:0]      r_wo, r_ho;
    logic [INDEX_BITS-1:0] r_pc, r_py, r_px, r_acc;
    logic                  r_err;

    logic                  r_o_valid;
    logic [IDX_OUT_W-1:0]  r_o_src, r_o_dst;
    logic [VALUE_W-1:0]    r_o_data;
    logic                  r_o_err;

    logic [DVS_W-1:0]      b2;
    logic                  d2s;
    logic                  div_start, div_done;
    logic [DIV_W-1:0]      div_dvd, div_quo;
    logic [DVS_W-1:0]      div_dvs, div_rem;
    logic [INDEX_BITS-1:0] mac_a, mac_c, mac;
    logic [OUT_W-1:0]      mac_b;
    logic [PW-1:0]         mac_full;
    logic                  load_out;
    logic [INDEX_BITS-1:0] dst;
    logic [EXT_W-1:0]      lin_ext, dst_ext;

    assign b2  = DVS_W'(i_b) * DVS_W'(i_b);
    assign d2s = (i_mode == MODE_D2S);

    psag_div #(
        .DIV_W(DIV_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // One multiply-add per step, registered into the step's target
    assign mac_full = PW'(mac_a) * PW'(mac_b) + PW'(mac_c);
    assign mac      = mac_full[INDEX_BITS-1:0];

    assign dst     = r_acc + r_base;
    assign lin_ext = EXT_W'(r_lin);
    assign dst_ext = EXT_W'(dst);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_issued  = r_issued;
        o_pop     = 1'b0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = DVS_W'(i_b);
        mac_a     = '0;
        mac_b     = OUT_W'(i_b);
        mac_c     = '0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_fifo.empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2, ST_DIV3, ST_DIV4: begin
                div_start = !r_issued;
                n_issued  = 1'b1;
                case (r_state)
                    ST_DIV1: begin
                        div_dvd = d2s ? DIV_W'(r_ch) : DIV_W'(r_x);
                        div_dvs = d2s ? b2 : DVS_W'(i_b);
                    end
                    ST_DIV2: begin
                        div_dvd = d2s ? DIV_W'(r_r1) : DIV_W'(r_y);
                    end
                    ST_DIV3: begin
                        div_dvd = d2s ? DIV_W'(i_c) : DIV_W'(i_w);
                        div_dvs = d2s ? b2 : DVS_W'(i_b);
                    end
                    default: begin
                        div_dvd = DIV_W'(i_h);
                    end
                endcase
                if (div_done) begin
                    n_issued = 1'b0;
                    case (r_state)
                        ST_DIV1: n_state = ST_DIV2;
                        ST_DIV2: n_state = ST_DIV3;
                        ST_DIV3: n_state = d2s ? ST_WO : ST_DIV4;
                        default: n_state = ST_T;
                    endcase
                end
            end
            ST_WO: begin
                mac_a   = INDEX_BITS'(i_w);
                n_state = ST_HO;
            end
            ST_HO: begin
                mac_a   = INDEX_BITS'(i_h);
                n_state = ST_PY;
            end
            ST_PY: begin
                mac_a   = INDEX_BITS'(r_y);
                mac_c   = r_py;
                n_state = ST_PX;
            end
            ST_PX: begin
                mac_a   = INDEX_BITS'(r_x);
                mac_c   = INDEX_BITS'(r_r2);
                n_state = ST_ACC;
            end
            ST_T: begin
                mac_a   = INDEX_BITS'(r_r2);
                mac_c   = INDEX_BITS'(r_r1);
                n_state = ST_PC;
            end
            ST_PC: begin
                mac_a   = INDEX_BITS'(r_ch);
                mac_b   = OUT_W'(b2);
                mac_c   = r_pc;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                mac_a   = r_pc;
                mac_b   = r_ho;
                mac_c   = r_py;
                n_state = ST_DST;
            end
            ST_DST: begin
                mac_a   = r_acc;
                mac_b   = r_wo;
                mac_c   = r_px;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_o_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    r_x    <= i_x;
                    r_y    <= i_y;
                    r_ch   <= i_ch;
                    r_base <= i_base;
                    r_lin  <= i_lin;
                    r_val  <= i_value;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    if (d2s) begin
                        r_pc <= INDEX_BITS'(div_quo);
                    end else begin
                        r_px <= INDEX_BITS'(div_quo);
                    end
                    r_r1 <= div_rem;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    r_py <= INDEX_BITS'(div_quo);
                    r_r2 <= div_rem;
                end
            end
            ST_DIV3: begin
                if (div_done) begin
                    r_err <= (div_rem != '0);
                    r_wo  <= OUT_W'(div_quo);
                end
            end
            ST_DIV4: begin
                if (div_done) begin
                    r_err <= r_err || (div_rem != '0);
                    r_ho  <= OUT_W'(div_quo);
                end
            end
            ST_WO:  r_wo  <= OUT_W'(mac);
            ST_HO:  r_ho  <= OUT_W'(mac);
            ST_PY:  r_py  <= mac;
            ST_PX:  r_px  <= mac;
            ST_T:   r_pc  <= mac;
            ST_PC:  r_pc  <= mac;
            ST_ACC: r_acc <= mac;
            ST_DST: r_acc <= mac;
            default: ;
        endcase
    end

    // Output register: hold until taken, reload in the same cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_src  <= lin_ext[IDX_OUT_W-1:0];
            r_o_dst  <= dst_ext[IDX_OUT_W-1:0];
            r_o_data <= r_val;
            r_o_err  <= r_err;
        end
    end

    assign o_valid = r_o_valid;
    assign o_src   = r_o_src;
    assign o_dst   = r_o_dst;
    assign o_data  = r_o_data;
    assign o_err   = r_o_err;

endmodule

// ===== rtl/pixel_shuffle_address_gen.sv =====
// Top level of the pixel shuffle (depth to space / space to depth) address generator.
// Depends on psag_pkg, psag_front, psag_fifo and psag_back.
//
// Usage:
//   Registers are written over the APB port (mode, block_size, width_in, height_in,
//   channels_in at byte addresses 0, 4, 8, 12, 16); pready is always high and a
//   read returns the stored register. Write them only while the block is idle.
//   Input stream: s_axis_tdata carries the element word, s_axis_tuser[0] marks the
//   first element of a tensor and clears all position counters.
//   Output stream: one item per input item with source index, destination index,
//   the word unchanged, and config_error in m_axis_tuser[0].
// Flow:
//   The front part takes an element and queues it (two entries), so it can take new
//   elements while the back part is busy. The back part works on one element at a
//   time; its shared radix-2 divider sets the rate.
//   After reset and after any register write the input is held off while the plane
//   size settles. A stalled receiver holds the output register; the back part waits
//   and the queue then fills and drops s_axis_tready.
module pixel_shuffle_address_gen
    import psag_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
    input  logic [0:0]            s_axis_tuser,   // [0] first
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*IDX_OUT_W+VALUE_W-1:0] m_axis_tdata, // [23:0] src_index,
                                                         // [47:24] dst_index,
                                                         // [79:48] data_out
    output logic [0:0]            m_axis_tuser    // [0] config_error
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int BLK_W = $clog2(MAX_BLOCK + 1);
    localparam int CD_W  = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    localparam int CB_W  = (BLK_W > BLOCK_CFG_W) ? BLK_W : BLOCK_CFG_W;
    localparam int JOB_W = 3 * CNT_W + 2 * INDEX_BITS + VALUE_W;

    // Zero reads as one, oversize saturates
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CD_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > CD_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(v);
        end
    endfunction

    function automatic logic [BLK_W-1:0] clamp_blk(input logic [CB_W-1:0] v);
        if (v == '0) begin
            return BLK_W'(1);
        end else if (v > CB_W'(MAX_BLOCK)) begin
            return BLK_W'(MAX_BLOCK);
        end else begin
            return BLK_W'(v);
        end
    endfunction

    logic                   r_mode;
    logic [BLOCK_CFG_W-1:0] r_block;
    logic [DIM_CFG_W-1:0]   r_width, r_height, r_chan;
    logic [BLK_W-1:0]       r_b_cl;
    logic [DIM_W-1:0]       r_w_cl, r_h_cl, r_c_cl;
    logic                   cfg_wr;
    t_reg_idx               reg_idx;

    logic                   push, pop;
    t_fifo_stat             fifo_stat;
    logic [CNT_W-1:0]       f_x, f_y, f_ch, b_x, b_y, b_ch;
    logic [INDEX_BITS-1:0]  f_base, f_lin, b_base, b_lin;
    logic [VALUE_W-1:0]     f_value, b_value;
    logic [JOB_W-1:0]       job_in, job_out;
    logic [IDX_OUT_W-1:0]   src_idx, dst_idx;
    logic [VALUE_W-1:0]     data_out;
    logic                   cfg_err;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_block  <= BLOCK_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_chan   <= CHAN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MODE:     r_mode   <= pwdata[0];
                REG_BLOCK:    r_block  <= pwdata[BLOCK_CFG_W-1:0];
                REG_WIDTH:    r_width  <= pwdata[DIM_CFG_W-1:0];
                REG_HEIGHT:   r_height <= pwdata[DIM_CFG_W-1:0];
                REG_CHANNELS: r_chan   <= pwdata[DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:     prdata = APB_DATA_W'(r_mode);
            REG_BLOCK:    prdata = APB_DATA_W'(r_block);
            REG_WIDTH:    prdata = APB_DATA_W'(r_width);
            REG_HEIGHT:   prdata = APB_DATA_W'(r_height);
            REG_CHANNELS: prdata = APB_DATA_W'(r_chan);
            default:      prdata = '0;
        endcase
    end

    // Register the clamped sizes; the front holds off input while they settle
    always_ff @(posedge i_clk) begin
        r_b_cl <= clamp_blk(CB_W'(r_block));
        r_w_cl <= clamp_dim(CD_W'(r_width));
        r_h_cl <= clamp_dim(CD_W'(r_height));
        r_c_cl <= clamp_dim(CD_W'(r_chan));
    end

    // ---------------- front: accept and count ----------------
    psag_front #(
        .INDEX_BITS(INDEX_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_w      (r_w_cl),
        .i_h      (r_h_cl),
        .i_c      (r_c_cl),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_value  (s_axis_tdata),
        .i_first  (s_axis_tuser[0]),
        .i_fifo   (fifo_stat),
        .o_push   (push),
        .o_x      (f_x),
        .o_y      (f_y),
        .o_ch     (f_ch),
        .o_base   (f_base),
        .o_lin    (f_lin),
        .o_value  (f_value)
    );

    // ---------------- job queue ----------------
    assign job_in = {f_value, f_lin, f_base, f_ch, f_y, f_x};

    psag_fifo #(
        .WIDTH(JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (job_in),
        .i_pop   (pop),
        .o_rdata (job_out),
        .o_stat  (fifo_stat)
    );

    assign {b_value, b_lin, b_base, b_ch, b_y, b_x} = job_out;

    // ---------------- back: index arithmetic ----------------
    psag_back #(
        .INDEX_BITS(INDEX_BITS),
        .MAX_DIM   (MAX_DIM),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_b     (r_b_cl),
        .i_w     (r_w_cl),
        .i_h     (r_h_cl),
        .i_c     (r_c_cl),
        .i_fifo  (fifo_stat),
        .o_pop   (pop),
        .i_x     (b_x),
        .i_y     (b_y),
        .i_ch    (b_ch),
        .i_base  (b_base),
        .i_lin   (b_lin),
        .i_value (b_value),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_src   (src_idx),
        .o_dst   (dst_idx),
        .o_data  (data_out),
        .o_err   (cfg_err)
    );

    assign m_axis_tdata    = {data_out, dst_idx, src_idx};
    assign m_axis_tuser[0] = cfg_err;

    // ---------------- checks ----------------
    a_fifo_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("job queue reports full and empty at once");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_stat.empty)
        else $error("back part popped an empty queue");

    a_cfg_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !s_axis_tready)
        else $error("input accepted before plane size settled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> !fifo_stat.full)
        else $error("job queue overflow");

endmodule

// ===== tb/sv/pixel_shuffle_address_gen_tb.sv =====
// Self-checking testbench for pixel_shuffle_address_gen: directed table, then random tensors.
// Depends on psag_pkg and the RTL of the block; an internal address predictor checks every item.
`timescale 1ns / 1ps

module pixel_shuffle_address_gen_tb;
    import psag_pkg::*;

    localparam int DRAIN_CYCLES = 80;       // above the space to depth latency
    localparam int PHASE_ITEMS  = 245;
    localparam longint unsigned IDX_MASK = (64'd1 << INDEX_BITS_DEF) - 1;

    // One result item: what the block is expected to emit for one element
    typedef struct packed {
        logic [IDX_OUT_W-1:0] src_idx;
        logic [IDX_OUT_W-1:0] dst_idx;
        logic [VALUE_W-1:0]   word;
        logic                 cfg_err;
    } t_addr_result;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_WRITE
    } t_row_kind;

    // One row of the directed table: an element or a register write
    typedef struct packed {
        t_row_kind    kind;
        t_reg_idx     reg_sel;
        logic [31:0]  arg;
        logic         first_el;
        logic         typed;
        t_addr_result want;
    } t_step_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [APB_ADDR_W-1:0]          paddr;
    logic [APB_DATA_W-1:0]          pwdata;
    logic [APB_DATA_W-1:0]          prdata;
    logic                           pready;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [VALUE_W-1:0]             s_axis_tdata;   // [31:0] value
    logic [0:0]                     s_axis_tuser;   // [0] first
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [2*IDX_OUT_W+VALUE_W-1:0] m_axis_tdata;   // [23:0] src_index, [47:24] dst_index,
                                                    // [79:48] data_out
    logic [0:0]                     m_axis_tuser;   // [0] config_error

    // Register shadow, kept in step with every APB write
    logic                 cfg_mode   = MODE_RST;
    logic [BLOCK_CFG_W-1:0] cfg_block  = BLOCK_RST;
    logic [DIM_CFG_W-1:0] cfg_width  = WIDTH_RST;
    logic [DIM_CFG_W-1:0] cfg_height = HEIGHT_RST;
    logic [DIM_CFG_W-1:0] cfg_chans  = CHAN_RST;

    // Predictor position state: element position within the tensor
    longint unsigned      pos_col;
    longint unsigned      pos_row;
    longint unsigned      pos_chan;
    longint unsigned      tensor_base;
    longint unsigned      src_count;

    t_addr_result         pending_addrs[$];
    int                   mismatch_count;
    int                   gap_pct;
    int                   hold_pct;
    t_step_row            dir_tab[$];

    pixel_shuffle_address_gen dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Give up after a fixed time, far beyond the slowest correct run
    initial begin
        #12_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Zero sizes count as one; oversized ones saturate at the hardware maximum
    function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    // Work out the source and destination index of one element and advance the position
    function automatic t_addr_result compute_addresses(logic [31:0] word, logic first_el);
        longint unsigned bsz, wd, ht, nch, b2, plane;
        longint unsigned x, y, ch, r, w_out, h_out, pc, py, px, dst;
        t_addr_result    res;
        bit              err;

        bsz   = clamp_size(cfg_block, MAX_BLOCK_DEF);
        wd    = clamp_size(cfg_width, MAX_DIM_DEF);
        ht    = clamp_size(cfg_height, MAX_DIM_DEF);
        nch   = clamp_size(cfg_chans, MAX_DIM_DEF);
        b2    = bsz * bsz;
        plane = (wd * ht * nch) & IDX_MASK;

        // A first element restarts the tensor before its own index is formed
        if (first_el) begin
            pos_col     = 0;
            pos_row     = 0;
            pos_chan    = 0;
            tensor_base = 0;
            src_count   = 0;
        end

        x  = pos_col;
        y  = pos_row;
        ch = pos_chan;

        if (cfg_mode == MODE_D2S) begin
            // Fold channel sub-index r into a b x b pixel block
            r     = ch % b2;
            err   = (nch % b2) != 0;
            w_out = wd * bsz;
            h_out = ht * bsz;
            pc    = ch / b2;
            py    = y * bsz + r / bsz;
            px    = x * bsz + r % bsz;
        end else begin
            // Pixel offset within its block becomes the channel sub-index
            err   = ((wd % bsz) != 0) || ((ht % bsz) != 0);
            w_out = wd / bsz;
            h_out = ht / bsz;
            pc    = ch * b2 + (y % bsz) * bsz + x % bsz;
            py    = y / bsz;
            px    = x / bsz;
        end
        dst = (tensor_base + (pc * h_out + py) * w_out + px) & IDX_MASK;

        res.src_idx = src_count[IDX_OUT_W-1:0];
        res.dst_idx = dst[IDX_OUT_W-1:0];
        res.word    = word;
        res.cfg_err = err;

        // Advance column, carry into row, channel and batch; counters left out of
        // range by a size change wrap at the end of this element
        src_count = (src_count + 1) & IDX_MASK;
        pos_col++;
        if (pos_col >= wd) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= ht) begin
                pos_row = 0;
                pos_chan++;
                if (pos_chan >= nch) begin
                    pos_chan    = 0;
                    tensor_base = (tensor_base + plane) & IDX_MASK;
                end
            end
        end
        if (pos_row >= ht)
            pos_row = 0;
        if (pos_chan >= nch)
            pos_chan = 0;
        return res;
    endfunction

    function automatic t_step_row row_item(logic [31:0] word, logic first_el);
        t_step_row row;
        row          = '0;
        row.kind     = ROW_ITEM;
        row.arg      = word;
        row.first_el = first_el;
        return row;
    endfunction

    function automatic t_step_row row_known(logic [31:0] word, logic first_el,
                                            int src, int dst, logic err);
        t_step_row row;
        row              = row_item(word, first_el);
        row.typed        = 1'b1;
        row.want.src_idx = IDX_OUT_W'(src);
        row.want.dst_idx = IDX_OUT_W'(dst);
        row.want.word    = word;
        row.want.cfg_err = err;
        return row;
    endfunction

    function automatic t_step_row row_write(t_reg_idx sel, logic [31:0] val);
        t_step_row row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_sel = sel;
        row.arg     = val;
        return row;
    endfunction

    // One APB transfer: setup phase, access phase, then psel drops and the bus idles
    task automatic apb_access(input logic wr, input t_reg_idx sel, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Read a register back and compare it with the shadow
    task automatic check_register(t_reg_idx sel);
        logic [31:0] rd;
        logic [31:0] want;
        apb_access(1'b0, sel, '0, rd);
        case (sel)
            REG_MODE:     want = 32'(cfg_mode);
            REG_BLOCK:    want = 32'(cfg_block);
            REG_WIDTH:    want = 32'(cfg_width);
            REG_HEIGHT:   want = 32'(cfg_height);
            default:      want = 32'(cfg_chans);
        endcase
        if (rd !== want) begin
            $error("register %s: expected %0d, got %0d", sel.name(), want, rd);
            mismatch_count++;
        end
    endtask

    task automatic apb_write(t_reg_idx sel, logic [31:0] val);
        logic [31:0] rd;
        apb_access(1'b1, sel, val, rd);
        case (sel)
            REG_MODE:     cfg_mode   = val[0];
            REG_BLOCK:    cfg_block  = val[BLOCK_CFG_W-1:0];
            REG_WIDTH:    cfg_width  = val[DIM_CFG_W-1:0];
            REG_HEIGHT:   cfg_height = val[DIM_CFG_W-1:0];
            default:      cfg_chans  = val[DIM_CFG_W-1:0];
        endcase
        check_register(sel);
    endtask

    // Offer one element, idling first at random; record its expectation on acceptance
    task automatic send_item(logic [31:0] word, logic first_el, logic typed, t_addr_result want);
        t_addr_result res;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= first_el;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        res = compute_addresses(word, first_el);
        pending_addrs.push_back(typed ? want : res);
        @(negedge i_clk);
    endtask

    // Hold the input until every expected item is out and the back part is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly small sizes so tensors wrap often; now and then an extreme
    function automatic logic [31:0] pick_dim();
        case ($urandom_range(19))
            0:       return 0;
            1:       return MAX_DIM_DEF;
            2:       return $urandom_range(MAX_DIM_DEF + 1, 8191);
            3:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Choose a new setting; most of them divide cleanly so the error flag stays low
    task automatic pick_config();
        logic [31:0] md, blk, wdt, hgt, chn;
        int unsigned be;
        md = $urandom_range(1);
        case ($urandom_range(9))
            0:       blk = 0;
            1:       blk = MAX_BLOCK_DEF;
            2:       blk = $urandom_range(MAX_BLOCK_DEF + 1, 15);
            default: blk = $urandom_range(1, 3);
        endcase
        be  = (blk == 0) ? 1 : ((blk > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : blk);
        wdt = pick_dim();
        hgt = pick_dim();
        chn = pick_dim();
        if ($urandom_range(9) < 7) begin
            if (md[0] == MODE_D2S) begin
                chn = be * be * $urandom_range(1, 3);
            end else begin
                wdt = be * $urandom_range(1, 3);
                hgt = be * $urandom_range(1, 3);
            end
        end
        if ($urandom_range(4) != 0) apb_write(REG_MODE, md);
        if ($urandom_range(4) != 0) apb_write(REG_BLOCK, blk);
        if ($urandom_range(4) != 0) apb_write(REG_WIDTH, wdt);
        if ($urandom_range(4) != 0) apb_write(REG_HEIGHT, hgt);
        if ($urandom_range(4) != 0) apb_write(REG_CHANNELS, chn);
    endtask

    // Receiver: stall at random with the current phase's probability
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= hold_pct);
        end
    end

    // Compare every accepted output item with the oldest expectation
    always @(posedge i_clk) begin
        t_addr_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_addrs.size() == 0) begin
                $error("output item with nothing expected: src_index %0d dst_index %0d",
                       m_axis_tdata[IDX_OUT_W-1:0], m_axis_tdata[2*IDX_OUT_W-1:IDX_OUT_W]);
                mismatch_count++;
            end else begin
                exp_r = pending_addrs.pop_front();
                if (m_axis_tdata[IDX_OUT_W-1:0] !== exp_r.src_idx) begin
                    $error("src_index: expected %0d, got %0d", exp_r.src_idx,
                           m_axis_tdata[IDX_OUT_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[2*IDX_OUT_W-1:IDX_OUT_W] !== exp_r.dst_idx) begin
                    $error("dst_index: expected %0d, got %0d", exp_r.dst_idx,
                           m_axis_tdata[2*IDX_OUT_W-1:IDX_OUT_W]);
                    mismatch_count++;
                end
                if (m_axis_tdata[2*IDX_OUT_W+VALUE_W-1:2*IDX_OUT_W] !== exp_r.word) begin
                    $error("data_out: expected %h, got %h", exp_r.word,
                           m_axis_tdata[2*IDX_OUT_W+VALUE_W-1:2*IDX_OUT_W]);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== exp_r.cfg_err) begin
                    $error("config_error: expected %0d, got %0d", exp_r.cfg_err,
                           m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int          sent;
        int          n;
        bit          wellformed;
        int          gap_tab[4];
        int          hold_tab[4];

        gap_tab  = '{0, 50, 0, 20};
        hold_tab = '{0, 0, 50, 20};
        mismatch_count = 0;
        gap_pct        = 0;
        hold_pct       = 0;
        pos_col        = 0;
        pos_row        = 0;
        pos_chan       = 0;
        tensor_base    = 0;
        src_count      = 0;

        // Drive every input to a known value while reset is held, then release reset
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All registers read back their reset values
        for (int i = 0; i <= int'(REG_CHANNELS); i++)
            check_register(t_reg_idx'(i));

        // Directed table. Reset setting: depth to space, block 2, 1x1 pixels, 4 channels.
        dir_tab = '{
            // four channels fold into one 2x2 block, then the next batch item starts
            row_known(32'h0000_0000, 1'b1, 0, 0, 1'b0),
            row_known(32'hFFFF_FFFF, 1'b0, 1, 1, 1'b0),
            row_known(32'hAAAA_AAAA, 1'b0, 2, 2, 1'b0),
            row_known(32'h5555_5555, 1'b0, 3, 3, 1'b0),
            row_known(32'h1234_5678, 1'b0, 4, 4, 1'b0),
            row_known(32'hDEAD_BEEF, 1'b1, 0, 0, 1'b0),
            // channel count not a multiple of the block area
            row_write(REG_CHANNELS, 3),
            row_known(32'h0F0F_0F0F, 1'b1, 0, 0, 1'b1),
            // space to depth; zero sizes count as one, oversized ones saturate
            row_write(REG_MODE, 32'(MODE_S2D)),
            row_write(REG_BLOCK, 0),
            row_write(REG_WIDTH, 8191),
            row_write(REG_HEIGHT, 0),
            row_write(REG_CHANNELS, 4097),
            row_item(32'h8000_0001, 1'b1),
            row_item(32'h7FFF_FFFE, 1'b0),
            row_item(32'hC3C3_3C3C, 1'b0),
            // largest block and dimensions
            row_write(REG_BLOCK, 15),
            row_write(REG_WIDTH, MAX_DIM_DEF),
            row_write(REG_HEIGHT, MAX_DIM_DEF),
            row_write(REG_CHANNELS, 8191),
            row_item(32'h0000_0001, 1'b1),
            row_item(32'hFFFF_FFFE, 1'b0),
            row_item(32'h3C3C_C3C3, 1'b0),
            row_write(REG_MODE, 32'(MODE_D2S)),
            row_write(REG_CHANNELS, MAX_DIM_DEF),
            row_item(32'h6666_9999, 1'b0),
            row_item(32'h9999_6666, 1'b0),
            // one element per tensor; block larger than the channel count
            row_write(REG_BLOCK, 9),
            row_write(REG_CHANNELS, 1),
            row_write(REG_WIDTH, 1),
            row_write(REG_HEIGHT, 1),
            row_known(32'h0000_FFFF, 1'b1, 0, 0, 1'b1),
            row_item(32'hFFFF_0000, 1'b0),
            // block of one; then shrink the channel count under a running counter
            row_write(REG_BLOCK, 1),
            row_write(REG_CHANNELS, 100),
            row_item(32'h0101_0101, 1'b1),
            row_item(32'h0202_0202, 1'b0),
            row_item(32'h0404_0404, 1'b0),
            row_item(32'h0808_0808, 1'b0),
            row_item(32'h1010_1010, 1'b0),
            row_write(REG_CHANNELS, 2),
            row_item(32'h2020_2020, 1'b0),
            row_item(32'h4040_4040, 1'b0)
        };
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_WRITE) begin
                drain_results();
                apb_write(dir_tab[i].reg_sel, dir_tab[i].arg);
            end else begin
                send_item(dir_tab[i].arg, dir_tab[i].first_el, dir_tab[i].typed,
                          dir_tab[i].want);
            end
        end
        drain_results();

        // Random tensors under each idling pattern. Most runs start with a first
        // element and stream in order; the rest scatter first marks or carry the
        // old position across a size change.
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct  = gap_tab[ph];
            hold_pct = hold_tab[ph];
            sent     = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(3) != 0) begin
                    drain_results();
                    pick_config();
                end
                wellformed = ($urandom_range(99) < 85);
                n = $urandom_range(4, 40);
                for (int k = 0; k < n; k++) begin
                    send_item($urandom(),
                              wellformed ? (k == 0) : ($urandom_range(7) == 0),
                              1'b0, '0);
                end
                sent += n;
            end
        end

        // Let the pipeline empty, then report
        drain_results();
        if (mismatch_count == 0 && pending_addrs.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/psag_pkg.sv
rtl/psag_front.sv
rtl/psag_fifo.sv
rtl/psag_div.sv
rtl/psag_back.sv
rtl/pixel_shuffle_address_gen.sv
tb/sv/pixel_shuffle_address_gen_tb.sv
